@@ rtl/mexp_pkg.sv @@
package mexp_pkg;

    // data path width of modulus, exponent, base and power
    localparam int WIDTH = 32;

    // width of the bit counter inside the serial multiplier
    localparam int CNT_W = $clog2(WIDTH);

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_MODULUS  = 1'b0,
        REG_EXPONENT = 1'b1
    } reg_index_t;

    // multiplier request: operands are latched when start is high
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] x;
        logic [WIDTH-1:0] y;
    } mul_req_t;

    // multiplier response: done pulses for one cycle with the product
    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] result;
    } mul_rsp_t;

    // finished word from the sequencer to the output register
    typedef struct packed {
        logic             valid;
        logic [WIDTH-1:0] power;
    } seq_rsp_t;

endpackage

@@ rtl/mexp_mulmod.sv @@
module mexp_mulmod (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mexp_pkg::mul_req_t               req,
    input  logic [mexp_pkg::WIDTH-1:0]       modulus,
    output mexp_pkg::mul_rsp_t               rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [mexp_pkg::CNT_W-1:0]    cnt_reg;
    logic [mexp_pkg::WIDTH-1:0]    x_reg;
    logic [mexp_pkg::WIDTH-1:0]    y_reg;
    logic [mexp_pkg::WIDTH-1:0]    acc_reg;
    logic [mexp_pkg::WIDTH-1:0]    acc_next;

    logic                          mod_zero;
    logic [mexp_pkg::WIDTH:0]      mod_ext;
    logic [mexp_pkg::WIDTH:0]      dbl;
    logic [mexp_pkg::WIDTH:0]      dbl_red;
    logic [mexp_pkg::WIDTH:0]      sum;
    logic [mexp_pkg::WIDTH:0]      sum_red;

    // one multiplier bit per cycle, msb first: acc = 2*acc + bit*x, reduced
    // a zero modulus stands for 2^WIDTH, so the sum just wraps
    always_comb
    begin
        mod_zero = (modulus == '0);
        mod_ext  = {1'b0, modulus};
        dbl      = {acc_reg, 1'b0};
        if (!mod_zero && (dbl >= mod_ext))
        begin
            dbl_red = dbl - mod_ext;
        end
        else
        begin
            dbl_red = dbl;
        end
        sum = {1'b0, dbl_red[mexp_pkg::WIDTH-1:0]}
            + (y_reg[mexp_pkg::WIDTH-1] ? {1'b0, x_reg} : '0);
        if (!mod_zero && (sum >= mod_ext))
        begin
            sum_red = sum - mod_ext;
        end
        else
        begin
            sum_red = sum;
        end
        acc_next = sum_red[mexp_pkg::WIDTH-1:0];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand shift register and accumulator
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= req.x;
            y_reg   <= req.y;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            y_reg   <= {y_reg[mexp_pkg::WIDTH-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

@@ rtl/mexp_seq.sv @@
module mexp_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [mexp_pkg::WIDTH-1:0]       base,
    input  logic [mexp_pkg::WIDTH-1:0]       modulus,
    input  logic [mexp_pkg::WIDTH-1:0]       exponent,
    input  logic                             slot_free,
    output mexp_pkg::mul_req_t               mul_req,
    input  mexp_pkg::mul_rsp_t               mul_rsp,
    output mexp_pkg::seq_rsp_t               result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_LOOP,
        S_MUL_P,
        S_MUL_S,
        S_DONE
    } state_t;

    state_t                        state_reg;
    logic [mexp_pkg::WIDTH-1:0]    exp_reg;
    logic [mexp_pkg::WIDTH-1:0]    prod_reg;
    logic [mexp_pkg::WIDTH-1:0]    sq_reg;
    logic                          start_reg;
    logic [mexp_pkg::WIDTH-1:0]    op_x_reg;
    logic [mexp_pkg::WIDTH-1:0]    op_y_reg;
    logic                          res_valid_reg;
    logic [mexp_pkg::WIDTH-1:0]    one_mod;

    // 1 mod n: zero only for a modulus of one
    assign one_mod = {{(mexp_pkg::WIDTH-1){1'b0}}, (modulus != mexp_pkg::WIDTH'(1))};

    // exponent scan, lsb first: multiply on a set bit, then square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            exp_reg       <= '0;
            prod_reg      <= '0;
            sq_reg        <= '0;
            start_reg     <= 1'b0;
            op_x_reg      <= '0;
            op_y_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (exponent == '0)
                        begin
                            prod_reg  <= mexp_pkg::WIDTH'(1);
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            // base mod n as (1 mod n) * base
                            exp_reg   <= exponent;
                            prod_reg  <= one_mod;
                            start_reg <= 1'b1;
                            op_x_reg  <= one_mod;
                            op_y_reg  <= base;
                            state_reg <= S_REDUCE;
                        end
                    end
                end
                S_REDUCE:
                begin
                    if (mul_rsp.done)
                    begin
                        sq_reg    <= mul_rsp.result;
                        state_reg <= S_LOOP;
                    end
                end
                S_LOOP:
                begin
                    if (exp_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (exp_reg[0])
                    begin
                        start_reg <= 1'b1;
                        op_x_reg  <= prod_reg;
                        op_y_reg  <= sq_reg;
                        state_reg <= S_MUL_P;
                    end
                    else
                    begin
                        start_reg <= 1'b1;
                        op_x_reg  <= sq_reg;
                        op_y_reg  <= sq_reg;
                        state_reg <= S_MUL_S;
                    end
                end
                S_MUL_P:
                begin
                    if (mul_rsp.done)
                    begin
                        prod_reg  <= mul_rsp.result;
                        exp_reg   <= {exp_reg[mexp_pkg::WIDTH-1:1], 1'b0};
                        state_reg <= S_LOOP;
                    end
                end
                S_MUL_S:
                begin
                    if (mul_rsp.done)
                    begin
                        sq_reg    <= mul_rsp.result;
                        exp_reg   <= {1'b0, exp_reg[mexp_pkg::WIDTH-1:1]};
                        state_reg <= S_LOOP;
                    end
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign mul_req.start = start_reg;
    assign mul_req.x     = op_x_reg;
    assign mul_req.y     = op_y_reg;
    assign result.valid  = res_valid_reg;
    assign result.power  = prod_reg;

endmodule

@@ rtl/modular_exponentiation.sv @@
// Raises each incoming base word to the configured exponent modulo the
// configured modulus (register 0 modulus, reset 1; register 1 exponent,
// reset 1; a zero modulus means arithmetic wraps at 32 bits, a zero exponent
// always gives 1). One base is worked on at a time. All arithmetic runs
// through a single bit-serial modular multiplier; an item with a nonzero
// exponent needs one product to reduce the base, then one square per
// exponent bit below the top set bit and one multiply per set bit. The
// finished word sits in an output register, so the next base is taken while
// the previous word waits on out_ready. Configuration must only be written
// while no item is in flight.
module modular_exponentiation (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mexp_pkg::WIDTH-1:0]    base,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mexp_pkg::WIDTH-1:0]    power,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [mexp_pkg::WIDTH-1:0]    cfg_data
);

    logic [mexp_pkg::WIDTH-1:0]    modulus_reg;
    logic [mexp_pkg::WIDTH-1:0]    exponent_reg;
    logic                          out_valid_reg;
    logic [mexp_pkg::WIDTH-1:0]    power_reg;
    logic                          slot_free;
    mexp_pkg::mul_req_t            mul_req;
    mexp_pkg::mul_rsp_t            mul_rsp;
    mexp_pkg::seq_rsp_t            seq_rsp;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= mexp_pkg::WIDTH'(1);
            exponent_reg <= mexp_pkg::WIDTH'(1);
        end
        else if (cfg_we)
        begin
            case (mexp_pkg::reg_index_t'(cfg_index))
                mexp_pkg::REG_MODULUS:  modulus_reg  <= cfg_data;
                mexp_pkg::REG_EXPONENT: exponent_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // exponent sequencer
    mexp_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .base      (base),
        .modulus   (modulus_reg),
        .exponent  (exponent_reg),
        .slot_free (slot_free),
        .mul_req   (mul_req),
        .mul_rsp   (mul_rsp),
        .result    (seq_rsp)
    );

    // shared serial modular multiplier
    mexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .modulus (modulus_reg),
        .rsp     (mul_rsp)
    );

    // output word register
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (seq_rsp.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_rsp.valid)
        begin
            power_reg <= seq_rsp.power;
        end
    end

    assign out_valid = out_valid_reg;
    assign power     = power_reg;

endmodule

@@ rtl/mexp_checker.sv @@
module mexp_assertions (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [mexp_pkg::WIDTH-1:0]    power
);

    // a stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power))
        else $error("output word changed while stalled");

    // the block goes busy once a base is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after accepting a word");

    // an idle block stays idle until a base arrives
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid |=> in_ready)
        else $error("ready dropped with no word accepted");

    // the word for a new base passes the sequencer and the output register, so out_valid does not rise for it at once
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind modular_exponentiation mexp_assertions u_mexp_assertions (.*);

@@ verif/mexp_checker.sv @@
module mexp_checker
    import mexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [WIDTH-1:0] base,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [WIDTH-1:0] power,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [WIDTH-1:0] cfg_data,
    output int               errors,
    output int               pending,
    output int               checked
);

    typedef struct {
        logic [WIDTH-1:0] base;
        logic [WIDTH-1:0] power;
    } power_entry_t;

    // local copy of the two registers
    logic [WIDTH-1:0] modulus_q;
    logic [WIDTH-1:0] exponent_q;

    // expected words in arrival order
    power_entry_t power_queue[$];

    // x * y reduced by n at full double width; n of zero wraps at WIDTH bits
    function automatic logic [WIDTH-1:0] mod_product(
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] y,
        input logic [WIDTH-1:0] n
    );
        logic [2*WIDTH-1:0] full;
        full = {{WIDTH{1'b0}}, x} * {{WIDTH{1'b0}}, y};
        if (n == '0)
            return full[WIDTH-1:0];
        return WIDTH'(full % {{WIDTH{1'b0}}, n});
    endfunction

    // right-to-left square and multiply over every exponent bit
    function automatic logic [WIDTH-1:0] mod_power(
        input logic [WIDTH-1:0] b,
        input logic [WIDTH-1:0] n,
        input logic [WIDTH-1:0] e
    );
        logic [WIDTH-1:0] sq;
        logic [WIDTH-1:0] acc;
        if (e == '0)
            return WIDTH'(1);
        if (n == '0) begin
            sq  = b;
            acc = WIDTH'(1);
        end
        else begin
            sq  = b % n;
            acc = (n == WIDTH'(1)) ? '0 : WIDTH'(1);
        end
        for (int i = 0; i < WIDTH; i++) begin
            if (e[i])
                acc = mod_product(acc, sq, n);
            sq = mod_product(sq, sq, n);
        end
        return acc;
    endfunction

    // track register writes, predict on accepted bases, compare on results
    always @(posedge clk or negedge rst_n)
    begin
        power_entry_t want;
        power_entry_t entry;
        if (!rst_n) begin
            modulus_q  <= WIDTH'(1);
            exponent_q <= WIDTH'(1);
            power_queue.delete();
            errors     <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else begin
            if (cfg_we) begin
                case (reg_index_t'(cfg_index))
                    REG_MODULUS:  modulus_q  <= cfg_data;
                    REG_EXPONENT: exponent_q <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                checked <= checked + 1;
                if (power_queue.size() == 0) begin
                    $display("%0t: unexpected power word %h, nothing expected (expected none)",
                             $time, power);
                    errors <= errors + 1;
                end
                else begin
                    want = power_queue.pop_front();
                    if (power !== want.power) begin
                        $display("%0t: power mismatch for base %h: expected %h, actual %h",
                                 $time, want.base, want.power, power);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && in_ready) begin
                entry.base  = base;
                entry.power = mod_power(base, modulus_q, exponent_q);
                power_queue.push_back(entry);
            end
            pending <= power_queue.size();
        end
    end

endmodule

@@ verif/tb.sv @@
module tb;
    import mexp_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 2500;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int RAND_PHASES  = 8;
    localparam int RAND_WORDS   = 34;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [WIDTH-1:0] base;
    logic             out_valid;
    logic             out_ready;
    logic [WIDTH-1:0] power;
    logic             cfg_we;
    logic [0:0]       cfg_index;
    logic [WIDTH-1:0] cfg_data;

    int errors;
    int pending;
    int checked;
    int cycles = 0;
    int words_sent = 0;
    int settings_used = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    logic [WIDTH-1:0] cur_modulus;

    modular_exponentiation i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .base      (base),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .power     (power),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mexp_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .base      (base),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .power     (power),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d words outstanding", cycles, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // offer one base word, with an optional random gap first
    task automatic send_base(input logic [WIDTH-1:0] b);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        in_valid <= 1'b1;
        base     <= b;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    // wait until every expected word has come back
    task automatic drain();
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // finish the current setting, then load a new one and a new idle mode
    task automatic configure(input logic [WIDTH-1:0] m, input logic [WIDTH-1:0] e);
        in_valid <= 1'b0;
        drain();
        repeat (40) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODULUS;
        cfg_data  <= m;
        @(posedge clk);
        cfg_index <= REG_EXPONENT;
        cfg_data  <= e;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_modulus = m;
        case (settings_used % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
            default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
        endcase
        settings_used++;
    endtask

    // random base, biased toward zero, all ones, the modulus edge and small values
    function automatic logic [WIDTH-1:0] pick_base(input logic [WIDTH-1:0] m);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return m - WIDTH'($urandom_range(0, 1));
            3: return WIDTH'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial
    begin
        logic [WIDTH-1:0] m;
        logic [WIDTH-1:0] e;
        int len;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        base      <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_MODULUS;
        cfg_data  <= '0;
        cur_modulus = WIDTH'(1);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset setting: modulus one with exponent one gives zero
        send_base('0);
        send_base('1);
        send_base(WIDTH'(12345));

        // zero modulus wraps at full width, largest exponent
        configure('0, '1);
        send_base('0);
        send_base(WIDTH'(1));
        send_base('1);
        send_base(WIDTH'(3));
        send_base(WIDTH'(32'h8000_0000));

        // zero exponent gives one even for modulus one
        configure(WIDTH'(1), '0);
        send_base('0);
        send_base('1);
        configure('1, '0);
        send_base(WIDTH'(7));

        // base at or above the modulus is reduced first
        configure(WIDTH'(1000003), WIDTH'(65537));
        send_base('1);
        send_base(WIDTH'(1000003));
        send_base(WIDTH'(1000004));
        send_base(WIDTH'(2));

        // largest modulus and exponent
        configure('1, '1);
        send_base(WIDTH'(32'hFFFF_FFFE));
        send_base('1);
        send_base('0);
        send_base(WIDTH'(2));

        // smallest useful modulus
        configure(WIDTH'(2), WIDTH'(1));
        send_base(WIDTH'(3));
        send_base(WIDTH'(32'hAAAA_AAAA));

        // random settings, each with a batch of random bases
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p % 4)
                0: m = $urandom | WIDTH'(32'h8000_0000);
                1: m = WIDTH'($urandom_range(2, 1000));
                2: m = '0;
                default: m = $urandom;
            endcase
            if (p == 0) begin
                e = '1;
            end
            else begin
                len = $urandom_range(1, WIDTH);
                e = ($urandom >> (WIDTH - len)) | (WIDTH'(1) << (len - 1));
            end
            configure(m, e);
            for (int k = 0; k < RAND_WORDS; k++)
                send_base(pick_base(cur_modulus));
        end

        // let everything come back and watch for stray words
        in_valid <= 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bases under %0d register settings plus the reset setting",
                 words_sent, settings_used);
        $display("compared %0d power words, %0d mismatches", checked, errors);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
